// ----- hw/rtl/bpr_pkg.sv -----
// shared types and constants for the binomial pyramid reduce block
package bpr_pkg;

	localparam int VAL_W     = 24;
	localparam int VAR_W     = 32;
	localparam int CFG_W     = 12;
	localparam int ROW_W     = 11;
	localparam int HEIGHT_LIMIT = 2048;
	localparam int VSUM_W    = 29;
	localparam int VABS_W    = 28;
	localparam int RSUM_W    = 38;
	localparam int SUM_W     = 5;
	localparam int DSQ_W     = 9;
	localparam int DIV_STEPS = 38;
	localparam int CNT_W     = 6;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic signed [VAL_W-1:0] sample_value;
		logic [VAR_W-1:0]        sample_variance;
		logic                    sample_usable;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic [VAR_W-1:0]        out_variance;
		logic                    out_usable;
		logic                    frame_last;
	} out_t;

	// packed pixel as kept in the line stores and the window
	typedef struct packed {
		logic                    usable;
		logic [VAR_W-1:0]        variance;
		logic signed [VAL_W-1:0] value;
	} pix_t;

	localparam int PIX_W = $bits(pix_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic fetch;
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
	} sts_t;

	// weights of the three taps along one axis: {w2, w1, w0}
	function automatic logic [5:0] tap_weights(input logic odd, input logic ge1,
			input logic ge2);
		logic [5:0] w;
		if (odd) begin
			w = {(ge2 ? 2'd1 : 2'd0), 2'd2, 2'd1};
		end else begin
			w = {2'd0, (ge1 ? 2'd1 : 2'd0), 2'd2};
		end
		return w;
	endfunction

endpackage

// ----- hw/rtl/bpr_ram.sv -----
// generic simple dual port ram with registered read
module bpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/bpr_ctrl.sv -----
// controller state machine for the pyramid reduce
module bpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bpr_pkg::sts_t sts,
	output bpr_pkg::cmd_t cmd
);

	bpr_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			bpr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = bpr_pkg::ST_FETCH;
				end
			end
			bpr_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = sts.emit ? bpr_pkg::ST_LOAD : bpr_pkg::ST_IDLE;
			end
			bpr_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = bpr_pkg::ST_DIV;
			end
			bpr_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = bpr_pkg::ST_OUT;
				end
			end
			bpr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = bpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/bpr_dp.sv -----
// datapath: position counters, line stores, 3x3 window, weighted sums, divider
module bpr_dp #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bpr_pkg::CFG_W-1:0]   cfg_data,
	input  bpr_pkg::in_t                in_data,
	output bpr_pkg::out_t               out_data,
	input  bpr_pkg::cmd_t               cmd,
	output bpr_pkg::sts_t               sts
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (XW + 1 > bpr_pkg::CFG_W) ? XW + 1 : bpr_pkg::CFG_W;

	logic [bpr_pkg::CFG_W-1:0] width_q, height_q;
	logic [XW-1:0]             col_q, x_q;
	logic [bpr_pkg::ROW_W-1:0] row_q;
	logic [CMPW-1:0]           w_eff, cfg_w_ext;
	logic [bpr_pkg::CFG_W-1:0] h_eff;
	logic                      last_col, last_row;
	logic                      emit_q, flast_q;
	logic [5:0]                cw_q, rw_q;
	bpr_pkg::pix_t             cur_s1, rd_a, rd_b;
	bpr_pkg::pix_t             win_q [6];
	logic [bpr_pkg::PIX_W-1:0] rd_a_raw, rd_b_raw;

	logic signed [bpr_pkg::VSUM_W-1:0] vsum_d, vsum_q;
	logic [bpr_pkg::RSUM_W-1:0]        rsum_d, rsum_q;
	logic [bpr_pkg::SUM_W-1:0]         s_d, s_q;
	logic                              neg_q;
	logic [bpr_pkg::VABS_W-1:0]        vabs;
	logic [bpr_pkg::DSQ_W-1:0]         dsq_q;
	logic [bpr_pkg::SUM_W-1:0]         vrem_q;
	logic [bpr_pkg::DSQ_W-1:0]         rrem_q;
	logic [bpr_pkg::RSUM_W-1:0]        vnum_q, rnum_q;
	logic [bpr_pkg::CNT_W-1:0]         cnt_q;
	logic [bpr_pkg::SUM_W:0]           vt;
	logic [bpr_pkg::DSQ_W:0]           rt;
	logic                              vbit, rbit;
	logic [bpr_pkg::VAL_W-1:0]         qv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bpr_pkg::CFG_W'(2048);
			height_q <= bpr_pkg::CFG_W'(2048);
		end else if (cfg_we) begin
			if (cfg_index == bpr_pkg::REG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// clamped sizes and edge flags of the current position
	always_comb begin
		cfg_w_ext = CMPW'(width_q);
		if (width_q == '0) begin
			w_eff = CMPW'(1);
		end else if (cfg_w_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = cfg_w_ext;
		end
		if (height_q == '0) begin
			h_eff = bpr_pkg::CFG_W'(1);
		end else if (height_q > bpr_pkg::CFG_W'(bpr_pkg::HEIGHT_LIMIT)) begin
			h_eff = bpr_pkg::CFG_W'(bpr_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
		last_col = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
		last_row = (bpr_pkg::CFG_W'(row_q) + bpr_pkg::CFG_W'(1)) >= h_eff;
	end

	// position counters and per-transaction flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			emit_q  <= 1'b0;
			flast_q <= 1'b0;
			x_q     <= '0;
			cw_q    <= '0;
			rw_q    <= '0;
		end else if (cmd.capture) begin
			x_q     <= col_q;
			emit_q  <= (col_q[0] || last_col) && (row_q[0] || last_row);
			flast_q <= last_col && last_row;
			cw_q    <= bpr_pkg::tap_weights(col_q[0], col_q != '0, col_q > XW'(1));
			rw_q    <= bpr_pkg::tap_weights(row_q[0], row_q != '0,
				row_q > bpr_pkg::ROW_W'(1));
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + bpr_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// incoming pixel
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_s1.value    <= in_data.sample_value;
			cur_s1.variance <= in_data.sample_variance;
			cur_s1.usable   <= in_data.sample_usable;
		end
	end

	// line stores: a holds the previous row, b the row before that
	bpr_ram #(.WIDTH(bpr_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk   (clk),
		.we    (cmd.fetch),
		.waddr (x_q),
		.wdata (cur_s1),
		.re    (cmd.capture),
		.raddr (col_q),
		.rdata (rd_a_raw)
	);

	bpr_ram #(.WIDTH(bpr_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk   (clk),
		.we    (cmd.fetch),
		.waddr (x_q),
		.wdata (rd_a_raw),
		.re    (cmd.capture),
		.raddr (col_q),
		.rdata (rd_b_raw)
	);

	assign rd_a = bpr_pkg::pix_t'(rd_a_raw);
	assign rd_b = bpr_pkg::pix_t'(rd_b_raw);

	// window of the two previous columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.fetch) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= cur_s1;
			win_q[1] <= rd_a;
			win_q[2] <= rd_b;
		end
	end

	// weighted sums over the nine taps
	always_comb begin
		bpr_pkg::pix_t tp [9];
		logic [2:0] wt;
		tp[0] = cur_s1;
		tp[1] = rd_a;
		tp[2] = rd_b;
		for (int i = 0; i < 6; i++) begin
			tp[i+3] = win_q[i];
		end
		vsum_d = '0;
		rsum_d = '0;
		s_d    = '0;
		for (int i = 0; i < 9; i++) begin
			wt = 3'(cw_q[2*(i/3) +: 2]) * 3'(rw_q[2*(i%3) +: 2]);
			if (!tp[i].usable) begin
				wt = 3'd0;
			end
			case (wt)
				3'd1: begin
					vsum_d = vsum_d + bpr_pkg::VSUM_W'(tp[i].value);
					rsum_d = rsum_d + bpr_pkg::RSUM_W'(tp[i].variance);
				end
				3'd2: begin
					vsum_d = vsum_d + (bpr_pkg::VSUM_W'(tp[i].value) <<< 1);
					rsum_d = rsum_d + (bpr_pkg::RSUM_W'(tp[i].variance) << 2);
				end
				3'd4: begin
					vsum_d = vsum_d + (bpr_pkg::VSUM_W'(tp[i].value) <<< 2);
					rsum_d = rsum_d + (bpr_pkg::RSUM_W'(tp[i].variance) << 4);
				end
				default: begin
					vsum_d = vsum_d;
				end
			endcase
			s_d = s_d + bpr_pkg::SUM_W'(wt);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			vsum_q <= vsum_d;
			rsum_q <= rsum_d;
			s_q    <= s_d;
		end
	end

	assign vabs = vsum_q[bpr_pkg::VSUM_W-1] ? bpr_pkg::VABS_W'(-vsum_q)
		: bpr_pkg::VABS_W'(vsum_q);

	// one quotient bit per cycle for value and variance
	always_comb begin
		vt   = {vrem_q, vnum_q[bpr_pkg::RSUM_W-1]};
		vbit = vt >= {1'b0, s_q};
		rt   = {rrem_q, rnum_q[bpr_pkg::RSUM_W-1]};
		rbit = rt >= {1'b0, dsq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= bpr_pkg::CNT_W'(bpr_pkg::DIV_STEPS);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - bpr_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= vsum_q[bpr_pkg::VSUM_W-1];
			dsq_q  <= bpr_pkg::DSQ_W'(s_q * s_q);
			vrem_q <= '0;
			rrem_q <= '0;
			vnum_q <= bpr_pkg::RSUM_W'(vabs) + bpr_pkg::RSUM_W'(s_q >> 1);
			rnum_q <= rsum_q + bpr_pkg::RSUM_W'((s_q * s_q) >> 1);
		end else if (cmd.step) begin
			vrem_q <= vbit ? bpr_pkg::SUM_W'(vt - {1'b0, s_q}) : vt[bpr_pkg::SUM_W-1:0];
			rrem_q <= rbit ? bpr_pkg::DSQ_W'(rt - {1'b0, dsq_q})
				: rt[bpr_pkg::DSQ_W-1:0];
			vnum_q <= {vnum_q[bpr_pkg::RSUM_W-2:0], vbit};
			rnum_q <= {rnum_q[bpr_pkg::RSUM_W-2:0], rbit};
		end
	end

	assign sts.emit     = emit_q;
	assign sts.div_last = cnt_q == bpr_pkg::CNT_W'(1);

	// result: sign, saturation, and the no-usable-tap case
	always_comb begin
		qv = vnum_q[bpr_pkg::VAL_W-1:0];
		out_data.frame_last = flast_q;
		if (s_q == '0) begin
			out_data.out_value    = '0;
			out_data.out_variance = '0;
			out_data.out_usable   = 1'b0;
		end else begin
			out_data.out_value    = neg_q ? -qv : qv;
			out_data.out_variance = (rnum_q[bpr_pkg::RSUM_W-1:bpr_pkg::VAR_W] != '0)
				? '1 : rnum_q[bpr_pkg::VAR_W-1:0];
			out_data.out_usable   = 1'b1;
		end
	end

endmodule

// ----- hw/rtl/binomial_pyramid_reduce_masked.sv -----
// masked 2:1 binomial pyramid reduce, top level
// one input transaction at a time: capture and fetch when it yields no result;
// when it does, also a load and the bit-serial divider, then the result is presented
// and held until taken; next input after delivery
// reset clears control, counters, window and size registers (2048 x 2048);
// line stores are not cleared and need no clearing pass
module binomial_pyramid_reduce_masked #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bpr_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpr_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bpr_pkg::CFG_W-1:0] cfg_data
);

	bpr_pkg::cmd_t cmd;
	bpr_pkg::sts_t sts;

	bpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpr_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
